### rtl/core/mmrs_pkg.sv
`default_nettype none

package mmrs_pkg;

  // fixed field widths of the stream items
  localparam int RowW   = 6;
  localparam int ColW   = 6;
  localparam int ValW   = 24;
  localparam int ProdW  = 2 * ValW;
  localparam int SumW   = 64;
  localparam int CfgW   = 7;
  localparam int CfgIdxW = 2;

  // packed beat widths, padded to whole bytes
  localparam int InDataW  = 40;
  localparam int OutDataW = 80;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgInnerLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgColCount = 2'd1;

  // input kinds carried in tuser
  localparam logic OpLoadB   = 1'b0;
  localparam logic OpStreamA = 1'b1;

  // one multiply-accumulate request into the shared unit
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] idx;
    logic            zero;
  } mmrs_issue_t;

  // accumulator write-back from the shared unit
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] idx;
    logic [SumW-1:0] data;
  } mmrs_wr_t;

endpackage

`default_nettype wire

### rtl/core/mmrs_mac.sv
`default_nettype none

module mmrs_mac
  import mmrs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mmrs_issue_t            issue_i,
  input  wire logic signed [ValW-1:0] a_i,
  input  wire logic signed [ValW-1:0] b_i,
  input  wire logic        [SumW-1:0] acc_i,
  output mmrs_wr_t                    wr_o
);

  logic                    v_q;
  logic [ColW-1:0]         idx_q;
  logic signed [ProdW-1:0] prod_q;
  logic [SumW-1:0]         acc_q;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= issue_i.valid;
    end
  end

  // product and old sum, the sum reads as zero at a row start
  always_ff @(posedge clk_i) begin
    idx_q  <= issue_i.idx;
    prod_q <= a_i * b_i;
    acc_q  <= issue_i.zero ? '0 : acc_i;
  end

  // accumulate, wraps modulo 2^64
  always_comb begin
    wr_o.valid = v_q;
    wr_o.idx   = idx_q;
    wr_o.data  = acc_q + SumW'(prod_q);
  end

endmodule

`default_nettype wire

### rtl/core/matrix_multiply_row_stream.sv
`default_nettype none

// Row-streaming matrix multiply C = A x B with signed Q12.12 operands and
// exact Q40.24 column sums.
// s_axis: tuser selects the kind of beat. A load beat (tuser 0) writes one
// element of B; the block stays idle. A stream beat (tuser 1) carries one
// element of A with its row tag and inner index t; it is multiplied by row t
// of B through one shared multiply-accumulate unit, one column a cycle, so it
// occupies the block until its last write-back is done; s_axis_tready stays low.
// A beat whose inner index is outside inner_len is dropped.
// After the last inner index the block sends col_count beats on m_axis, one
// per column with tlast on the final column; each result passes through the
// accumulator memory read, the output register and the beat, and the block
// holds the beat as long as m_axis_tready is low.
// cfg: index 0 is inner_len, index 1 is col_count, always ready; write only
// while the block is idle.
// Reset sets both registers to 64 and clears the accumulator valid bits;
// the B store is not cleared and must be written before use.

module matrix_multiply_row_stream
  import mmrs_pkg::*;
#(
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  // input beats
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // row_index [5:0], col_index [11:6], value [35:12], zero pad [39:36]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // operation [0]
  input  wire logic                s_axis_tuser_i,
  // result beats
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // out_row [5:0], out_col [11:6], sum [75:12], zero pad [79:76]
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tlast_o
);

  localparam int Depth = MAX_INNER * MAX_COLS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int JW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int IW    = $clog2(MAX_INNER + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_RD,
    S_LOAD,
    S_SHOW
  } state_e;

  state_e state_q;

  logic [CfgW-1:0] cfg_inner_q;
  logic [CfgW-1:0] cfg_cols_q;

  // input fields
  logic                   in_op;
  logic [RowW-1:0]        in_row;
  logic [ColW-1:0]        in_col;
  logic signed [ValW-1:0] in_val;

  assign in_op  = s_axis_tuser_i;
  assign in_row = s_axis_tdata_i[5:0];
  assign in_col = s_axis_tdata_i[11:6];
  assign in_val = s_axis_tdata_i[35:12];

  // effective sizes, clamped
  logic [IW-1:0] n_eff;
  logic [CW-1:0] k_eff;

  always_comb begin
    if (cfg_inner_q == '0) begin
      n_eff = IW'(1);
    end else if (int'(cfg_inner_q) > MAX_INNER) begin
      n_eff = IW'(MAX_INNER);
    end else begin
      n_eff = IW'(cfg_inner_q);
    end
    if (cfg_cols_q == '0) begin
      k_eff = CW'(1);
    end else if (int'(cfg_cols_q) > MAX_COLS) begin
      k_eff = CW'(MAX_COLS);
    end else begin
      k_eff = CW'(cfg_cols_q);
    end
  end

  logic in_beat;
  logic load_we;
  logic load_in_range;
  logic stream_ok;

  assign in_beat       = s_axis_tvalid_i && s_axis_tready_o;
  assign load_in_range = (int'(in_row) < MAX_INNER) && (int'(in_col) < MAX_COLS);
  assign load_we       = in_beat && (in_op == OpLoadB) && load_in_range;
  assign stream_ok     = in_beat && (in_op == OpStreamA) && (int'(in_col) < int'(n_eff));

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_inner_q <= 7'd64;
      cfg_cols_q  <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgInnerLen: cfg_inner_q <= cfg_data_i;
        CfgColCount: cfg_cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item and sequencer
  logic signed [ValW-1:0] a_q;
  logic [RowW-1:0]        t_q;
  logic [RowW-1:0]        row_q;
  logic [CW-1:0]          k_q;
  logic                   last_t_q;
  logic [CW-1:0]          j_q;

  logic [RowW-1:0]        out_row_q;
  logic [ColW-1:0]        out_col_q;
  logic [SumW-1:0]        out_sum_q;
  logic                   out_last_q;

  logic                   j_last;
  mmrs_wr_t               wr;
  logic                   rd_v_q;
  logic [SumW-1:0]        acc_rd_q;

  assign j_last = (j_q == k_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      a_q        <= '0;
      t_q        <= '0;
      row_q      <= '0;
      k_q        <= '0;
      last_t_q   <= 1'b0;
      j_q        <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_sum_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (stream_ok) begin
            a_q      <= in_val;
            t_q      <= in_col;
            row_q    <= in_row;
            k_q      <= k_eff;
            last_t_q <= (int'(in_col) == int'(n_eff) - 1);
            j_q      <= '0;
            state_q  <= S_MAC;
          end
        end
        // one column issued per cycle
        S_MAC: begin
          if (j_last) begin
            j_q     <= '0;
            state_q <= S_DRAIN;
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        // wait for the last write-back
        S_DRAIN: begin
          if (!rd_v_q && !wr.valid) begin
            state_q <= last_t_q ? S_RD : S_IDLE;
          end
        end
        S_RD: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          out_row_q  <= row_q;
          out_col_q  <= ColW'(j_q);
          out_last_q <= j_last;
          state_q    <= S_SHOW;
        end
        S_SHOW: begin
          if (m_axis_tready_i) begin
            if (out_last_q) begin
              state_q <= S_IDLE;
            end else begin
              j_q     <= j_q + CW'(1);
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_LOAD) begin
        out_sum_q <= acc_rd_q;
      end
    end
  end

  // B store, undefined until written
  logic signed [ValW-1:0] b_mem [Depth];
  logic signed [ValW-1:0] b_rd_q;
  logic [AW-1:0]          b_waddr;
  logic [AW-1:0]          b_raddr;

  assign b_waddr = AW'(int'(in_row) * MAX_COLS + int'(in_col));
  assign b_raddr = AW'(int'(t_q) * MAX_COLS + int'(j_q));

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      b_mem[b_waddr] <= in_val;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rd_q <= b_mem[b_raddr];
  end

  // column accumulators with per-column valid bits
  logic [SumW-1:0]     acc_mem [MAX_COLS];
  logic [MAX_COLS-1:0] acc_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr.valid) begin
      acc_mem[wr.idx[JW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_rd_q <= acc_mem[j_q[JW-1:0]];
  end

  // inner index zero clears every column, not only the active ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= '0;
    end else if (stream_ok && (in_col == '0)) begin
      acc_valid_q <= '0;
    end else if (wr.valid) begin
      acc_valid_q[wr.idx[JW-1:0]] <= 1'b1;
    end
  end

  // read stage in step with the registered memory reads
  logic [ColW-1:0] rd_j_q;
  logic            rd_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= (state_q == S_MAC);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_j_q    <= ColW'(j_q);
    rd_zero_q <= (t_q == '0) || !acc_valid_q[j_q[JW-1:0]];
  end

  // shared multiply-accumulate unit
  mmrs_issue_t issue;

  always_comb begin
    issue.valid = rd_v_q;
    issue.idx   = rd_j_q;
    issue.zero  = rd_zero_q;
  end

  mmrs_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .a_i     (a_q),
    .b_i     (b_rd_q),
    .acc_i   (acc_rd_q),
    .wr_o    (wr)
  );

  // handshake outputs
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_SHOW);
  assign m_axis_tdata_o  = {4'b0, out_sum_q, out_col_q, out_row_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  // inputs and results never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while a result is pending");

  // accumulator reads for output only after write-back is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (!wr.valid && !rd_v_q))
    else $error("output read races accumulator write-back");

  // result columns stay within the latched column count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (int'(out_col_q) < int'(k_q)))
    else $error("result column out of range");

  // a result beat held under stall keeps its column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(out_col_q)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
